// ----- design/hfd_pkg.sv -----
`default_nettype none

package hfd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ADDRESS_SET    = 3'd0;
    localparam logic [2:0] CFG_BUS_ASSIGNED   = 3'd1;
    localparam logic [2:0] CFG_BUS_READY      = 3'd2;
    localparam logic [2:0] CFG_HEATER_ON      = 3'd3;
    localparam logic [2:0] CFG_CRC_CHECK      = 3'd4;
    localparam logic [2:0] CFG_PRECISION_MODE = 3'd5;

    // Precision codes and the measure commands they select.
    localparam logic [1:0] PREC_HIGH   = 2'd0;
    localparam logic [1:0] PREC_MEDIUM = 2'd1;
    localparam logic [1:0] PREC_LOW    = 2'd2;
    localparam logic [7:0] CMD_HIGH    = 8'hFD;
    localparam logic [7:0] CMD_MEDIUM  = 8'hF6;
    localparam logic [7:0] CMD_LOW     = 8'hE0;

    // Error flag bits.
    localparam logic [4:0] FLAG_NONE           = 5'h00;
    localparam logic [4:0] FLAG_NOT_CONFIGURED = 5'h01;
    localparam logic [4:0] FLAG_INVALID_CONFIG = 5'h02;
    localparam logic [4:0] FLAG_BUS_FAILURE    = 5'h04;
    localparam logic [4:0] FLAG_COMM_FAILURE   = 5'h08;
    localparam logic [4:0] FLAG_CRC_FAILURE    = 5'h10;

    // CRC-8 parameters.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Scaling: value = round(SPAN * raw / 65535) - OFFSET.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [12:0] TEMP_OFFSET = 13'd4500;
    localparam logic [14:0] HUM_SPAN    = 15'd12500;
    localparam logic [12:0] HUM_OFFSET  = 13'd600;
    localparam logic [30:0] ROUND_HALF  = 31'd32767;
    localparam logic [31:0] DIVISOR     = 32'd65535;

    // Pipeline stage advance strobes shared by the datapath slices.
    typedef struct packed {
        logic en_b;
        logic en_c;
    } t_stage_en;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Measure command for a precision code; the unused code means high.
    function automatic logic [7:0] command_for(input logic [1:0] mode);
        logic [7:0] cmd;
        case (mode)
            PREC_MEDIUM: cmd = CMD_MEDIUM;
            PREC_LOW:    cmd = CMD_LOW;
            PREC_HIGH:   cmd = CMD_HIGH;
            default:     cmd = CMD_HIGH;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

// ----- design/hfd_crc_chk.sv -----
`default_nettype none

module hfd_crc_chk (
    input  wire logic              i_clk,
    input  wire hfd_pkg::t_stage_en i_en,
    input  wire logic [15:0]       i_word,
    input  wire logic [7:0]        i_check,
    output logic                   o_ok
);

    logic [7:0] r_crc_hi;
    logic [7:0] r_lo;
    logic [7:0] r_check;
    logic       r_ok;

    // Stage B: fold in the high byte, keep the low byte and the check byte.
    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_crc_hi <= hfd_pkg::crc8_byte(hfd_pkg::CRC_INIT, i_word[15:8]);
            r_lo     <= i_word[7:0];
            r_check  <= i_check;
        end
    end

    // Stage C: fold in the low byte and compare.
    always_ff @(posedge i_clk) begin
        if (i_en.en_c) begin
            r_ok <= (hfd_pkg::crc8_byte(r_crc_hi, r_lo) == r_check);
        end
    end

    assign o_ok = r_ok;

endmodule

`default_nettype wire

// ----- design/hfd_scale.sv -----
`default_nettype none

module hfd_scale (
    input  wire logic              i_clk,
    input  wire hfd_pkg::t_stage_en i_en,
    input  wire logic [15:0]       i_raw,
    input  wire logic [14:0]       i_span,
    input  wire logic [12:0]       i_offset,
    output logic signed [14:0]     o_value
);

    logic [30:0] n_x;
    logic [30:0] r_x;
    logic [31:0] n_est_sum;
    logic [30:0] r_x_c;
    logic [14:0] r_q;
    logic [31:0] rem;
    logic        corr;
    logic [14:0] q_fin;

    // Stage B: span * raw plus half the divisor for rounding.
    assign n_x = ({15'd0, i_raw} * {16'd0, i_span}) + hfd_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_x <= n_x;
        end
    end

    // Stage C: quotient estimate x / 65535 ~ (x + x/65536) / 65536, low by at most one.
    assign n_est_sum = {1'b0, r_x} + {17'd0, r_x[30:16]};

    always_ff @(posedge i_clk) begin
        if (i_en.en_c) begin
            r_x_c <= r_x;
            r_q   <= n_est_sum[30:16];
        end
    end

    // Remainder check corrects the estimate, then the offset is removed.
    assign rem     = {1'b0, r_x_c} - {1'b0, r_q, 16'd0} + {17'd0, r_q};
    assign corr    = (rem >= hfd_pkg::DIVISOR);
    assign q_fin   = r_q + {14'd0, corr};
    assign o_value = signed'(q_fin - {2'd0, i_offset});

endmodule

`default_nettype wire

// ----- design/humidity_temp_frame_decoder_top.sv -----
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------------
// in        | in        | i_in_valid / o_in_ready    | bus_ok, temp_raw, temp_check, hum_raw,
//           |           |                            | hum_check
// out       | out       | o_out_valid / i_out_ready  | valid_res, fault_mask, measure_command,
//           |           |                            | temperature_centi, humidity_centi
// cfg       | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Four register stages: input capture, CRC high byte and multiply, CRC low byte and
// quotient estimate, then correction, flags and the output register. One item is taken
// every cycle while the output does not stall; the multiply in stage B sets the clock.
// Reset clears the stage valid bits and sets the configuration registers to CRC check on, high precision, all else off.
// A stall at the output fills the empty stages first and then holds every stage in place.

module humidity_temp_frame_decoder_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input channel.
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_bus_ok,
    input  wire logic [15:0]       i_temp_raw,
    input  wire logic [7:0]        i_temp_check,
    input  wire logic [15:0]       i_hum_raw,
    input  wire logic [7:0]        i_hum_check,
    // Output channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_valid_res,
    output logic [4:0]             o_fault_mask,
    output logic [7:0]             o_measure_command,
    output logic signed [14:0]     o_temperature_centi,
    output logic signed [14:0]     o_humidity_centi,
    // Configuration channel.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [1:0]        i_cfg_data
);

    // Configuration registers.
    logic       r_address_set;
    logic       r_bus_assigned;
    logic       r_bus_ready;
    logic       r_heater_on;
    logic       r_crc_check;
    logic [1:0] r_precision_mode;

    // Stage valid bits and the bus status that travels alongside.
    logic r_va, r_vb, r_vc, r_vd;
    logic r_a_bus_ok, r_b_bus_ok, r_c_bus_ok;

    // Stage A payload.
    logic [15:0] r_a_temp_raw;
    logic [7:0]  r_a_temp_check;
    logic [15:0] r_a_hum_raw;
    logic [7:0]  r_a_hum_check;

    // Output register.
    logic              r_valid_res;
    logic [4:0]        r_fault_mask;
    logic [7:0]        r_measure_command;
    logic signed [14:0] r_temperature_centi;
    logic signed [14:0] r_humidity_centi;

    logic               en_a, en_d;
    hfd_pkg::t_stage_en stage_en;
    logic               temp_crc_ok, hum_crc_ok;
    logic signed [14:0] temp_value, hum_value;
    logic               n_valid_res;
    logic [4:0]         n_fault_mask;

    // A stage moves on when it is empty or the stage after it moves.
    assign en_d          = !r_vd || i_out_ready;
    assign stage_en.en_c = !r_vc || en_d;
    assign stage_en.en_b = !r_vb || stage_en.en_c;
    assign en_a          = !r_va || stage_en.en_b;
    assign o_in_ready    = en_a;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_set    <= 1'b0;
            r_bus_assigned   <= 1'b0;
            r_bus_ready      <= 1'b0;
            r_heater_on      <= 1'b0;
            r_crc_check      <= 1'b1;
            r_precision_mode <= hfd_pkg::PREC_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hfd_pkg::CFG_ADDRESS_SET:    r_address_set    <= i_cfg_data[0];
                hfd_pkg::CFG_BUS_ASSIGNED:   r_bus_assigned   <= i_cfg_data[0];
                hfd_pkg::CFG_BUS_READY:      r_bus_ready      <= i_cfg_data[0];
                hfd_pkg::CFG_HEATER_ON:      r_heater_on      <= i_cfg_data[0];
                hfd_pkg::CFG_CRC_CHECK:      r_crc_check      <= i_cfg_data[0];
                hfd_pkg::CFG_PRECISION_MODE: r_precision_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_in_valid;
            end
            if (stage_en.en_b) begin
                r_vb <= r_va;
            end
            if (stage_en.en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
        end
    end

    // Stage A captures the item; bus status rides along to stage C.
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_bus_ok     <= i_bus_ok;
            r_a_temp_raw   <= i_temp_raw;
            r_a_temp_check <= i_temp_check;
            r_a_hum_raw    <= i_hum_raw;
            r_a_hum_check  <= i_hum_check;
        end
        if (stage_en.en_b) begin
            r_b_bus_ok <= r_a_bus_ok;
        end
        if (stage_en.en_c) begin
            r_c_bus_ok <= r_b_bus_ok;
        end
    end

    hfd_crc_chk u_temp_crc (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_word  (r_a_temp_raw),
        .i_check (r_a_temp_check),
        .o_ok    (temp_crc_ok)
    );

    hfd_crc_chk u_hum_crc (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_word  (r_a_hum_raw),
        .i_check (r_a_hum_check),
        .o_ok    (hum_crc_ok)
    );

    hfd_scale u_temp_scale (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_raw    (r_a_temp_raw),
        .i_span   (hfd_pkg::TEMP_SPAN),
        .i_offset (hfd_pkg::TEMP_OFFSET),
        .o_value  (temp_value)
    );

    hfd_scale u_hum_scale (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_raw    (r_a_hum_raw),
        .i_span   (hfd_pkg::HUM_SPAN),
        .i_offset (hfd_pkg::HUM_OFFSET),
        .o_value  (hum_value)
    );

    // Readiness and response checks in priority order.
    always_comb begin
        n_valid_res  = 1'b0;
        n_fault_mask = hfd_pkg::FLAG_NONE;
        if (!(r_address_set && r_bus_assigned && r_bus_ready)) begin
            n_fault_mask = hfd_pkg::FLAG_NOT_CONFIGURED;
        end else if (r_heater_on) begin
            n_fault_mask = hfd_pkg::FLAG_INVALID_CONFIG | hfd_pkg::FLAG_NOT_CONFIGURED;
        end else if (!r_c_bus_ok) begin
            n_fault_mask = hfd_pkg::FLAG_BUS_FAILURE | hfd_pkg::FLAG_COMM_FAILURE;
        end else if (r_crc_check && !(temp_crc_ok && hum_crc_ok)) begin
            n_fault_mask = hfd_pkg::FLAG_CRC_FAILURE;
        end else begin
            n_valid_res = 1'b1;
        end
    end

    // Output register; values read as zero on an invalid result.
    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_valid_res         <= n_valid_res;
            r_fault_mask        <= n_fault_mask;
            r_measure_command   <= hfd_pkg::command_for(r_precision_mode);
            r_temperature_centi <= n_valid_res ? temp_value : 15'sd0;
            r_humidity_centi    <= n_valid_res ? hum_value : 15'sd0;
        end
    end

    assign o_out_valid         = r_vd;
    assign o_valid_res         = r_valid_res;
    assign o_fault_mask        = r_fault_mask;
    assign o_measure_command   = r_measure_command;
    assign o_temperature_centi = r_temperature_centi;
    assign o_humidity_centi    = r_humidity_centi;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hfd_pkg::*;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PRINT_LIMIT     = 50;

    // Register indexes past the last implemented register; writes there are ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        bit       address_set;
        bit       bus_assigned;
        bit       bus_ready;
        bit       heater_on;
        bit       crc_check;
        bit [1:0] precision_mode;
    } t_cfg;

    typedef struct packed {
        bit        bus_ok;
        bit [15:0] temp_raw;
        bit [7:0]  temp_check;
        bit [15:0] hum_raw;
        bit [7:0]  hum_check;
    } t_frame;

    typedef struct packed {
        logic        valid_res;
        logic [4:0]  fault_mask;
        logic [7:0]  measure_command;
        logic [14:0] temperature_centi;
        logic [14:0] humidity_centi;
    } t_reading;

    typedef struct packed {
        t_cfg     cfg;
        t_frame   frame;
        bit       seal;   // Fill in the correct CRC bytes before sending.
        bit       typed;  // Compare against the reading typed into the row.
        t_reading want;
    } t_row;

    // Register settings: address_set, bus_assigned, bus_ready, heater_on, crc_check, mode.
    localparam t_cfg CFG_RESET_STATE = {5'b00001, PREC_HIGH};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_bus_ok;
    logic [15:0] i_temp_raw;
    logic [7:0]  i_temp_check;
    logic [15:0] i_hum_raw;
    logic [7:0]  i_hum_check;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_valid_res;
    logic [4:0]  o_fault_mask;
    logic [7:0]  o_measure_command;
    logic signed [14:0] o_temperature_centi;
    logic signed [14:0] o_humidity_centi;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [1:0]  i_cfg_data;

    t_cfg     model_cfg;
    t_reading pending_readings[$];
    t_row     directed_rows[$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    int       recv_gap       = 0;
    bit       hold_req       = 1'b0;
    bit       hold_off       = 1'b0;

    humidity_temp_frame_decoder_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_bus_ok            (i_bus_ok),
        .i_temp_raw          (i_temp_raw),
        .i_temp_check        (i_temp_check),
        .i_hum_raw           (i_hum_raw),
        .i_hum_check         (i_hum_check),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_valid_res         (o_valid_res),
        .o_fault_mask        (o_fault_mask),
        .o_measure_command   (o_measure_command),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // CRC-8 over one big-endian word, one bit at a time.
    function automatic bit [7:0] crc8_of_word(input bit [15:0] word);
        bit [7:0] crc;
        bit       feedback;
        crc = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            feedback = crc[7] ^ word[i];
            crc = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    // round(span * raw / 65535) - offset, cut to the 15-bit output field.
    function automatic logic [14:0] scale_centi(input longint span, input longint offset,
                                                input bit [15:0] raw);
        longint value;
        value = (2 * span * longint'(raw) + 65535) / 131070 - offset;
        return value[14:0];
    endfunction

    function automatic logic [7:0] command_of(input bit [1:0] mode);
        logic [7:0] cmd;
        case (mode)
            PREC_MEDIUM: cmd = CMD_MEDIUM;
            PREC_LOW:    cmd = CMD_LOW;
            default:     cmd = CMD_HIGH;
        endcase
        return cmd;
    endfunction

    // Expected reading for one frame under the given register settings.
    function automatic t_reading decode_frame(input t_cfg c, input t_frame f);
        t_reading r;
        r = '0;
        r.measure_command = command_of(c.precision_mode);
        if (!c.address_set || !c.bus_assigned || !c.bus_ready) begin
            r.fault_mask = FLAG_NOT_CONFIGURED;
        end else if (c.heater_on) begin
            r.fault_mask = FLAG_INVALID_CONFIG | FLAG_NOT_CONFIGURED;
        end else if (!f.bus_ok) begin
            r.fault_mask = FLAG_BUS_FAILURE | FLAG_COMM_FAILURE;
        end else if (c.crc_check && (crc8_of_word(f.temp_raw) != f.temp_check ||
                                     crc8_of_word(f.hum_raw) != f.hum_check)) begin
            r.fault_mask = FLAG_CRC_FAILURE;
        end else begin
            r.valid_res         = 1'b1;
            r.fault_mask        = FLAG_NONE;
            r.temperature_centi = scale_centi(TEMP_SPAN, TEMP_OFFSET, f.temp_raw);
            r.humidity_centi    = scale_centi(HUM_SPAN, HUM_OFFSET, f.hum_raw);
        end
        return r;
    endfunction

    function automatic t_reading reading(input logic v, input logic [4:0] flags,
                                         input logic [7:0] cmd, input int temp, input int hum);
        t_reading r;
        r.valid_res         = v;
        r.fault_mask        = flags;
        r.measure_command   = cmd;
        r.temperature_centi = temp[14:0];
        r.humidity_centi    = hum[14:0];
        return r;
    endfunction

    function automatic void add_row(input t_cfg c, input bit ok, input bit [15:0] t,
                                    input bit [7:0] tc, input bit [15:0] h, input bit [7:0] hc,
                                    input bit seal, input bit typed, input t_reading want);
        t_row row;
        row.cfg   = c;
        row.frame = {ok, t, tc, h, hc};
        row.seal  = seal;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Raw words lean toward the two ends of the range now and then.
    function automatic bit [15:0] pick_raw();
        bit [15:0] raw;
        case ($urandom_range(0, 15))
            0:       raw = 16'h0000;
            1:       raw = 16'hFFFF;
            default: raw = 16'($urandom);
        endcase
        return raw;
    endfunction

    // Mostly well-formed frames, with some corrupted check bytes and bus failures.
    function automatic t_frame random_frame();
        t_frame f;
        f.bus_ok     = ($urandom_range(0, 9) != 0);
        f.temp_raw   = pick_raw();
        f.hum_raw    = pick_raw();
        f.temp_check = crc8_of_word(f.temp_raw);
        f.hum_check  = crc8_of_word(f.hum_raw);
        case ($urandom_range(0, 9))
            0: f.temp_check = 8'($urandom);
            1: f.hum_check  = 8'($urandom);
            2: f.temp_check = f.temp_check ^ (8'h01 << $urandom_range(0, 7));
            3: f.hum_check  = f.hum_check ^ (8'h01 << $urandom_range(0, 7));
            default: ;
        endcase
        return f;
    endfunction

    function automatic int pick_idle_pct();
        int pct;
        case ($urandom_range(0, 2))
            0:       pct = 0;
            1:       pct = 15;
            default: pct = 40;
        endcase
        return pct;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Offer one item, possibly after an idle burst, and record its expected reading.
    task automatic send_frame(input t_frame f, input bit typed, input t_reading want);
        int gap;
        @(negedge i_clk);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_bus_ok     <= f.bus_ok;
        i_temp_raw   <= f.temp_raw;
        i_temp_check <= f.temp_check;
        i_hum_raw    <= f.hum_raw;
        i_hum_check  <= f.hum_check;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(typed ? want : decode_frame(model_cfg, f));
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait for every pending reading, then let the pipeline settle.
    task automatic drain_readings();
        int waited;
        waited = 0;
        while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_readings.size() != 0) begin
            report_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
            pending_readings.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ADDRESS_SET:    model_cfg.address_set    = data[0];
            CFG_BUS_ASSIGNED:   model_cfg.bus_assigned   = data[0];
            CFG_BUS_READY:      model_cfg.bus_ready      = data[0];
            CFG_HEATER_ON:      model_cfg.heater_on      = data[0];
            CFG_CRC_CHECK:      model_cfg.crc_check      = data[0];
            CFG_PRECISION_MODE: model_cfg.precision_mode = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Bring the block to idle and load a full register setting. With pad set, the unused
    // upper data bit of the one-bit registers is randomized; a spare index may be written.
    task automatic apply_cfg(input t_cfg c, input bit pad);
        finish_burst();
        drain_readings();
        write_reg(CFG_ADDRESS_SET,    {pad && ($urandom_range(0, 1) == 1), c.address_set});
        write_reg(CFG_BUS_ASSIGNED,   {pad && ($urandom_range(0, 1) == 1), c.bus_assigned});
        write_reg(CFG_BUS_READY,      {pad && ($urandom_range(0, 1) == 1), c.bus_ready});
        write_reg(CFG_HEATER_ON,      {pad && ($urandom_range(0, 1) == 1), c.heater_on});
        write_reg(CFG_CRC_CHECK,      {pad && ($urandom_range(0, 1) == 1), c.crc_check});
        write_reg(CFG_PRECISION_MODE, c.precision_mode);
        if (pad && $urandom_range(0, 2) == 0) begin
            write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      2'($urandom_range(0, 3)));
        end
    endtask

    // Output side: random stall bursts, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (recv_gap != 0) begin
            i_out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
            i_out_ready <= 1'b0;
            recv_gap <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Long hold-off so the pipeline fills and the input channel stalls.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Compare each accepted reading with the oldest expected one.
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_valid_res, o_fault_mask, o_measure_command,
                   o_temperature_centi, o_humidity_centi};
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("reading %h with no item pending", got));
            end else begin
                want = pending_readings.pop_front();
                if (got.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res got %b want %b",
                                              got.valid_res, want.valid_res));
                if (got.fault_mask !== want.fault_mask)
                    report_mismatch($sformatf("fault_mask got %h want %h",
                                              got.fault_mask, want.fault_mask));
                if (got.measure_command !== want.measure_command)
                    report_mismatch($sformatf("measure_command got %h want %h",
                                              got.measure_command, want.measure_command));
                if (got.temperature_centi !== want.temperature_centi)
                    report_mismatch($sformatf("temperature_centi got %0d want %0d",
                                              $signed(got.temperature_centi),
                                              $signed(want.temperature_centi)));
                if (got.humidity_centi !== want.humidity_centi)
                    report_mismatch($sformatf("humidity_centi got %0d want %0d",
                                              $signed(got.humidity_centi),
                                              $signed(want.humidity_centi)));
            end
        end
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #(2_000_000);
        $display("humidity_temp_frame_decoder_top test failed");
        $finish;
    end

    // Reset, directed table, random phases, final check.
    initial begin
        t_frame   f;
        t_cfg     c;
        t_reading none;

        none         = '0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_bus_ok     = 1'b0;
        i_temp_raw   = '0;
        i_temp_check = '0;
        i_hum_raw    = '0;
        i_hum_check  = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ADDRESS_SET;
        i_cfg_data   = '0;
        model_cfg    = CFG_RESET_STATE;

        // Registers straight out of reset: not configured, high precision command.
        add_row(CFG_RESET_STATE, 1'b1, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        // Each readiness bit missing on its own, then all three missing with the heater on.
        add_row({5'b11001, PREC_HIGH}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        add_row({5'b01101, PREC_HIGH}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        add_row({5'b10101, PREC_HIGH}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        add_row({5'b00011, PREC_HIGH}, 1'b0, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        // Heater on wins over bus failure.
        add_row({5'b11111, PREC_HIGH}, 1'b1, 16'hFFFF, 8'hAC, 16'hFFFF, 8'hAC, 1'b0, 1'b1,
                reading(1'b0, FLAG_INVALID_CONFIG | FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        add_row({5'b11111, PREC_HIGH}, 1'b0, 16'hFFFF, 8'h00, 16'hFFFF, 8'h00, 1'b0, 1'b1,
                reading(1'b0, FLAG_INVALID_CONFIG | FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        // Bus failure wins over a bad CRC.
        add_row({5'b11101, PREC_HIGH}, 1'b0, 16'h0000, 8'h00, 16'hFFFF, 8'h00, 1'b0, 1'b1,
                reading(1'b0, FLAG_BUS_FAILURE | FLAG_COMM_FAILURE, CMD_HIGH, 0, 0));
        // Both ends of the raw range with correct CRC bytes.
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b1, FLAG_NONE, CMD_HIGH, -4500, -600));
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'hFFFF, 8'hAC, 16'hFFFF, 8'hAC, 1'b0, 1'b1,
                reading(1'b1, FLAG_NONE, CMD_HIGH, 13000, 11900));
        // A wrong CRC byte on either word.
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'h0000, 8'h80, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_CRC_FAILURE, CMD_HIGH, 0, 0));
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'hFFFF, 8'hAC, 16'hFFFF, 8'h2C, 1'b0, 1'b1,
                reading(1'b0, FLAG_CRC_FAILURE, CMD_HIGH, 0, 0));
        // CRC check off: bad bytes pass, bus failure still counts.
        add_row({5'b11100, PREC_HIGH}, 1'b1, 16'hFFFF, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b1,
                reading(1'b1, FLAG_NONE, CMD_HIGH, 13000, -600));
        add_row({5'b11100, PREC_HIGH}, 1'b0, 16'hFFFF, 8'hAC, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_BUS_FAILURE | FLAG_COMM_FAILURE, CMD_HIGH, 0, 0));
        // Each precision, the command following the mode even on invalid readings.
        add_row({5'b11101, PREC_MEDIUM}, 1'b1, 16'h0000, 8'h81, 16'hFFFF, 8'hAC, 1'b0, 1'b1,
                reading(1'b1, FLAG_NONE, CMD_MEDIUM, -4500, 11900));
        add_row({5'b00001, PREC_LOW}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_NOT_CONFIGURED, CMD_LOW, 0, 0));
        add_row({5'b11101, PREC_LOW}, 1'b1, 16'hBEEF, 8'h92, 16'h1234, 8'h00, 1'b1, 1'b0,
                none);
        // The unused precision code selects the high precision command.
        add_row({5'b11101, 2'd3}, 1'b1, 16'h8000, 8'h00, 16'h7FFF, 8'h00, 1'b1, 1'b0, none);
        add_row({5'b11111, 2'd3}, 1'b1, 16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
                reading(1'b0, FLAG_INVALID_CONFIG | FLAG_NOT_CONFIGURED, CMD_HIGH, 0, 0));
        // Values next to the ends and alternating bit patterns.
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'h0001, 8'h00, 16'hFFFE, 8'h00, 1'b1, 1'b0,
                none);
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'hFFFE, 8'h00, 16'h0001, 8'h00, 1'b1, 1'b0,
                none);
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'h5555, 8'h00, 16'hAAAA, 8'h00, 1'b1, 1'b0,
                none);
        add_row({5'b11101, PREC_HIGH}, 1'b1, 16'hAAAA, 8'h00, 16'h5555, 8'h00, 1'b1, 1'b0,
                none);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        send_idle_pct = 25;
        recv_idle_pct = 25;
        foreach (directed_rows[k]) begin
            f = directed_rows[k].frame;
            if (directed_rows[k].seal) begin
                f.temp_check = crc8_of_word(f.temp_raw);
                f.hum_check  = crc8_of_word(f.hum_raw);
            end
            if (directed_rows[k].cfg != model_cfg) begin
                apply_cfg(directed_rows[k].cfg, 1'b0);
            end
            send_frame(f, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            c.address_set  = 1'b1;
            c.bus_assigned = 1'b1;
            c.bus_ready    = 1'b1;
            c.heater_on    = 1'b0;
            if ($urandom_range(0, 9) >= 7) begin
                c.address_set  = 1'($urandom_range(0, 1));
                c.bus_assigned = 1'($urandom_range(0, 1));
                c.bus_ready    = 1'($urandom_range(0, 1));
                c.heater_on    = 1'($urandom_range(0, 1));
            end
            c.crc_check      = ($urandom_range(0, 4) != 0);
            c.precision_mode = 2'($urandom_range(0, 3));
            apply_cfg(c, 1'b1);

            if (p == RANDOM_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end else begin
                send_idle_pct = pick_idle_pct();
                recv_idle_pct = pick_idle_pct();
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_frame(random_frame(), 1'b0, none);
            end
        end

        finish_burst();
        drain_readings();
        if (mismatch_count == 0) begin
            $display("humidity_temp_frame_decoder_top test passed");
        end else begin
            $display("humidity_temp_frame_decoder_top test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hfd_pkg.sv
design/hfd_crc_chk.sv
design/hfd_scale.sv
design/humidity_temp_frame_decoder_top.sv
tb/sv/tb_top.sv
